@@ hw/rtl/rrqs_pkg.sv @@
// Shared types, constants and helpers for the round-robin quantum scheduler.
// No dependencies; imported by every module in hw/rtl.
package rrqs_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_RUN     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_SHIFT = 2'd1,
        OP_WRITE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic        done;
    } entry_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] key;
    } cell_ctl_t;

    typedef struct packed {
        logic        run;
        logic [15:0] len;
        logic        fin;
    } slice_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] len;
        logic [31:0] total;
        logic        slice_valid;
        logic        fin;
        logic        all_done;
        status_t     status;
        logic        last;
    } result_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ hw/rtl/rrqs_cell.sv @@
// One table cell of the scheduler chain: holds one process entry.
// Depends on rrqs_pkg for entry and control types.
module rrqs_cell (
    input  logic               clk,
    input  rrqs_pkg::cell_ctl_t ctl,
    input  rrqs_pkg::entry_t   nbr,
    input  rrqs_pkg::entry_t   wr,
    output rrqs_pkg::entry_t   q,
    output logic               hit
);
    import rrqs_pkg::*;

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        case (ctl.op)
            OP_SHIFT: q_next = nbr;
            OP_WRITE: q_next = wr;
            default:  q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q   = q_reg;
    assign hit = (q_reg.id == ctl.key);

endmodule

@@ hw/rtl/rrqs_slice.sv @@
// Slice unit at the head of the chain: eligibility, slice length, time update.
// Depends on rrqs_pkg for entry and slice types and the saturating add.
module rrqs_slice (
    input  rrqs_pkg::entry_t head,
    input  logic             in_range,
    input  logic [31:0]      cur_time,
    input  logic [31:0]      total_time,
    input  logic [15:0]      quantum,
    output rrqs_pkg::entry_t upd,
    output rrqs_pkg::slice_t info,
    output logic [31:0]      cur_after,
    output logic [31:0]      tot_after
);
    import rrqs_pkg::*;

    logic        elig;
    logic [15:0] len;
    logic [15:0] rem_left;

    always_comb
    begin
        elig     = in_range && !head.done && ({16'd0, head.arrival} <= cur_time);
        len      = (head.remaining < quantum) ? head.remaining : quantum;
        rem_left = head.remaining - len;
        upd      = head;
        if (elig)
        begin
            upd.remaining = rem_left;
            upd.done      = (rem_left == 16'd0);
        end
        info.run  = elig;
        info.len  = len;
        info.fin  = (rem_left == 16'd0);
        cur_after = sat_add(cur_time, {16'd0, len});
        tot_after = sat_add(total_time, {16'd0, len});
    end

endmodule

@@ hw/rtl/round_robin_quantum_scheduler.sv @@
// Round-robin quantum scheduler: request decode, cell chain and result output.
// Depends on rrqs_pkg, rrqs_cell and rrqs_slice.
//
// Usage: drive req_type, proc_id, arrival_time and burst_length with start;
// an item is taken at a clock edge with start high and busy low. Results come
// on the result ports for one cycle each, marked by result_valid; last marks
// the final result of an item. The receiver cannot stall the block.
// Add, remove and restart results show in the next cycle and busy stays low,
// so these items can be issued back to back.
// A pass rotates the whole cell chain once through the slice unit at its head,
// one entry per cycle, while busy is high. Each slice result is held until the
// next slice of the pass runs and shows in the cycle after that; the final one
// shows in the first cycle with busy low.
// A run request that finds every entry finished answers like an add.
// The quantum register must be written with cfg_we and cfg_wdata only while
// idle; the block itself does not enforce this.
// Reset empties the table, clears both time counters and sets quantum to 4;
// entries themselves are not cleared, only the fill count.
module round_robin_quantum_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  proc_id,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        result_valid,
    output logic [7:0]  ran_id,
    output logic [15:0] slice_length,
    output logic [31:0] total_elapsed,
    output logic        slice_valid,
    output logic        proc_finished,
    output logic        all_done,
    output logic [1:0]  status,
    output logic        last
);
    import rrqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_TAIL = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        cur_reg, cur_next;
    logic [31:0]        tot_reg, tot_next;
    logic [15:0]        quantum_reg, quantum_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;
    logic               result_valid_reg, result_valid_next;
    result_t            out_reg, out_next;

    entry_t                 cell_q [TABLE_SLOTS];
    cell_ctl_t              cell_ctl [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] hit_vec;
    logic [TABLE_SLOTS-1:0] valid_mask;
    logic [TABLE_SLOTS-1:0] done_vec;
    logic [TABLE_SLOTS-1:0] match_vec;
    logic [TABLE_SLOTS-1:0] low_bit;
    logic [TABLE_SLOTS-1:0] shift_mask;
    entry_t                 wr_entry;
    entry_t                 head_upd;
    slice_t                 slice_info;
    logic [31:0]            cur_after;
    logic [31:0]            tot_after;
    logic                   in_range;
    logic                   accept;
    logic                   full;
    logic                   found;
    logic                   all_fin;
    logic                   do_add;
    logic                   do_rem;
    logic                   do_scan;
    req_t                   req;
    result_t                plain_res;

    assign req      = req_t'(req_type);
    assign accept   = start && (state_reg == S_IDLE);
    assign wr_entry = '{id: proc_id, arrival: arrival_time, remaining: burst_length,
                        done: 1'b0};
    assign in_range = ({1'b0, k_reg} < count_reg);

    for (genvar g = 0; g < TABLE_SLOTS; g++)
    begin : g_cell
        entry_t nbr;
        if (g == TABLE_SLOTS - 1)
        begin : g_tail
            assign nbr = head_upd;
        end
        else
        begin : g_body
            assign nbr = cell_q[g+1];
        end

        assign valid_mask[g] = (CNT_W'(g) < count_reg);
        assign done_vec[g]   = cell_q[g].done;

        always_comb
        begin
            cell_ctl[g].key = proc_id;
            if (do_scan || (do_rem && shift_mask[g]))
            begin
                cell_ctl[g].op = OP_SHIFT;
            end
            else if (do_add && (count_reg == CNT_W'(g)))
            begin
                cell_ctl[g].op = OP_WRITE;
            end
            else
            begin
                cell_ctl[g].op = OP_HOLD;
            end
        end

        rrqs_cell u_cell (
            .clk (clk),
            .ctl (cell_ctl[g]),
            .nbr (nbr),
            .wr  (wr_entry),
            .q   (cell_q[g]),
            .hit (hit_vec[g])
        );
    end

    rrqs_slice u_slice (
        .head       (cell_q[0]),
        .in_range   (in_range),
        .cur_time   (cur_reg),
        .total_time (tot_reg),
        .quantum    (quantum_reg),
        .upd        (head_upd),
        .info       (slice_info),
        .cur_after  (cur_after),
        .tot_after  (tot_after)
    );

    assign match_vec  = hit_vec & valid_mask;
    assign found      = |match_vec;
    assign low_bit    = match_vec & (~match_vec + TABLE_SLOTS'(1));
    assign shift_mask = ~(low_bit - TABLE_SLOTS'(1));
    assign full       = (count_reg >= CNT_W'(TABLE_SLOTS));
    assign all_fin    = &(done_vec | ~valid_mask);
    assign do_add     = accept && (req == REQ_ADD) && !full;
    assign do_rem     = accept && (req == REQ_REMOVE) && found;
    assign do_scan    = (state_reg == S_SCAN);

    always_comb
    begin
        plain_res = '{id: 8'd0, len: 16'd0, total: tot_reg, slice_valid: 1'b0,
                      fin: 1'b0, all_done: 1'b0, status: ST_OK, last: 1'b1};

        state_next        = state_reg;
        k_next            = k_reg;
        count_next        = count_reg;
        cur_next          = cur_reg;
        tot_next          = tot_reg;
        quantum_next      = cfg_we ? cfg_wdata : quantum_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        result_valid_next = 1'b0;
        out_next          = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_valid_next = 1'b1;
                    out_next          = plain_res;
                    case (req)
                        REQ_ADD:
                        begin
                            if (full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (found)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                out_next.status = ST_NOT_FOUND;
                            end
                        end
                        REQ_RESTART:
                        begin
                            cur_next = 32'd0;
                        end
                        default:
                        begin
                            if (all_fin)
                            begin
                                out_next.all_done = 1'b1;
                            end
                            else
                            begin
                                result_valid_next = 1'b0;
                                state_next        = S_SCAN;
                                k_next            = '0;
                                pend_valid_next   = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (slice_info.run)
                begin
                    cur_next = cur_after;
                    tot_next = tot_after;
                    if (pend_valid_reg)
                    begin
                        result_valid_next = 1'b1;
                        out_next          = pend_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_next = '{id: cell_q[0].id, len: slice_info.len, total: tot_after,
                                  slice_valid: 1'b1, fin: slice_info.fin, all_done: 1'b0,
                                  status: ST_OK, last: 1'b0};
                end
                if (k_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_TAIL:
            begin
                cur_next          = sat_add(cur_reg, 32'd1);
                result_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                end
                else
                begin
                    out_next = plain_res;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= '0;
            count_reg        <= '0;
            cur_reg          <= 32'd0;
            tot_reg          <= 32'd0;
            quantum_reg      <= 16'd4;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            count_reg        <= count_next;
            cur_reg          <= cur_next;
            tot_reg          <= tot_next;
            quantum_reg      <= quantum_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign ran_id        = out_reg.id;
    assign slice_length  = out_reg.len;
    assign total_elapsed = out_reg.total;
    assign slice_valid   = out_reg.slice_valid;
    assign proc_finished = out_reg.fin;
    assign all_done      = out_reg.all_done;
    assign status        = out_reg.status;
    assign last          = out_reg.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SLOTS))
        else $error("entry count above table size");

    a_slice_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && out_reg.slice_valid) |->
        (out_reg.status == ST_OK) && !out_reg.all_done)
        else $error("slice result with error status or all_done");

    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL) |=> (result_valid_reg && out_reg.last))
        else $error("pass ended without a final result");

    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && k_reg != IDX_W'(TABLE_SLOTS - 1)) |=>
        (state_reg == S_SCAN) && $stable(count_reg))
        else $error("scan left early or table size changed in a pass");

    a_pend_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending slice left behind after a pass");

endmodule
